### src/llaa_pkg.sv
package llaa_pkg;

    // table geometry and field widths
    localparam int NUM_ADDRS = 8;
    localparam int IDX_W     = 3;
    localparam int CNT_W     = 16;
    localparam int N_W       = 4;
    localparam int REQ_W     = 7;
    localparam int MAX_BATCH = 64;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // operation codes
    localparam logic OP_ASSIGN  = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // configuration register indexes
    localparam logic REG_ADDRS_IN_USE = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RANK,
        ST_PLACE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             operation;
        logic [REQ_W-1:0] request_count;
        logic [IDX_W-1:0] release_index;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] address_index;
        logic             last_of_batch;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic release_op;
        logic rank_step;
        logic place_step;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_release;
        logic in_nop;
        logic step_last;
        logic out_free;
        logic batch_last;
    } t_status;

endpackage

### src/llaa_ctrl.sv
module llaa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  llaa_pkg::t_status i_status,
    output logic              o_stall,
    output llaa_pkg::t_cmd    o_cmd,
    output llaa_pkg::t_state  o_state
);

    llaa_pkg::t_state r_state;
    llaa_pkg::t_state n_state;
    logic             accept;

    // items are taken only between batches
    assign accept  = i_valid && (r_state == llaa_pkg::ST_IDLE);
    assign o_stall = (r_state != llaa_pkg::ST_IDLE);
    assign o_state = r_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            llaa_pkg::ST_IDLE: begin
                if (accept && !i_status.in_release && !i_status.in_nop) begin
                    n_state = llaa_pkg::ST_RANK;
                end
            end
            llaa_pkg::ST_RANK: begin
                if (i_status.step_last) begin
                    n_state = llaa_pkg::ST_PLACE;
                end
            end
            llaa_pkg::ST_PLACE: begin
                if (i_status.step_last) begin
                    n_state = llaa_pkg::ST_EMIT;
                end
            end
            llaa_pkg::ST_EMIT: begin
                if (i_status.out_free && i_status.batch_last) begin
                    n_state = llaa_pkg::ST_IDLE;
                end
            end
            default: n_state = llaa_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            llaa_pkg::ST_IDLE: begin
                o_cmd.release_op = accept && i_status.in_release;
                o_cmd.start      = accept && !i_status.in_release && !i_status.in_nop;
            end
            llaa_pkg::ST_RANK:  o_cmd.rank_step  = 1'b1;
            llaa_pkg::ST_PLACE: o_cmd.place_step = 1'b1;
            llaa_pkg::ST_EMIT:  o_cmd.emit       = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= llaa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### src/llaa_dp.sv
module llaa_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  llaa_pkg::t_in_item       i_data,
    input  logic [llaa_pkg::N_W-1:0] i_num_active,
    input  llaa_pkg::t_cmd           i_cmd,
    input  logic                     i_stall,
    output llaa_pkg::t_status        o_status,
    output logic                     o_valid,
    output llaa_pkg::t_out_item      o_data
);

    logic [llaa_pkg::CNT_W-1:0] r_cnt   [llaa_pkg::NUM_ADDRS];
    logic [llaa_pkg::IDX_W-1:0] r_rank  [llaa_pkg::NUM_ADDRS];
    logic [llaa_pkg::IDX_W-1:0] r_order [llaa_pkg::NUM_ADDRS];
    logic [llaa_pkg::IDX_W-1:0] r_step;
    logic [llaa_pkg::IDX_W-1:0] r_pos;
    logic [llaa_pkg::N_W-1:0]   r_num;
    logic [llaa_pkg::REQ_W-1:0] r_left;
    logic                       r_out_valid;
    llaa_pkg::t_out_item        r_out;

    logic [llaa_pkg::REQ_W-1:0] req_clamped;
    logic [llaa_pkg::CNT_W-1:0] step_cnt;
    logic [llaa_pkg::IDX_W-1:0] emit_idx;
    logic [llaa_pkg::IDX_W-1:0] rel_idx;
    logic                       out_free;

    // request clamp to the batch limit
    assign req_clamped = (i_data.request_count > llaa_pkg::REQ_W'(llaa_pkg::MAX_BATCH))
                       ? llaa_pkg::REQ_W'(llaa_pkg::MAX_BATCH) : i_data.request_count;

    assign step_cnt = r_cnt[r_step];
    assign emit_idx = r_order[r_pos];
    assign rel_idx  = i_data.release_index;
    assign out_free = !r_out_valid || !i_stall;

    // status back to the controller
    always_comb begin
        o_status.in_release = (i_data.operation == llaa_pkg::OP_RELEASE);
        o_status.in_nop     = (i_num_active == '0) || (req_clamped == '0);
        o_status.step_last  = ((llaa_pkg::N_W'(r_step) + llaa_pkg::N_W'(1)) == r_num);
        o_status.out_free   = out_free;
        o_status.batch_last = (r_left == llaa_pkg::REQ_W'(1));
    end

    // batch bookkeeping: step index, emit position, remaining results
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_num  <= i_num_active;
            r_left <= req_clamped;
            r_step <= '0;
            r_pos  <= '0;
        end else if (i_cmd.rank_step) begin
            r_step <= o_status.step_last ? '0 : r_step + llaa_pkg::IDX_W'(1);
        end else if (i_cmd.place_step) begin
            r_step <= r_step + llaa_pkg::IDX_W'(1);
        end else if (i_cmd.emit) begin
            r_left <= r_left - llaa_pkg::REQ_W'(1);
            r_pos  <= ((llaa_pkg::N_W'(r_pos) + llaa_pkg::N_W'(1)) == r_num)
                    ? '0 : r_pos + llaa_pkg::IDX_W'(1);
        end
    end

    // rank pass: one reference entry per cycle compared against every entry in use
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < llaa_pkg::NUM_ADDRS; i++) begin
            if (i_cmd.start) begin
                r_rank[i] <= '0;
            end else if (i_cmd.rank_step) begin
                if ((llaa_pkg::N_W'(i) < r_num) &&
                    ((step_cnt < r_cnt[i]) ||
                     ((step_cnt == r_cnt[i]) && (r_step < llaa_pkg::IDX_W'(i))))) begin
                    r_rank[i] <= r_rank[i] + llaa_pkg::IDX_W'(1);
                end
            end
        end
    end

    // place pass: entry goes to the slot given by its rank
    always_ff @(posedge i_clk) begin
        if (i_cmd.place_step) begin
            r_order[r_rank[r_step]] <= r_step;
        end
    end

    // use counts: raised on hand-out, lowered on release, both saturating
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < llaa_pkg::NUM_ADDRS; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (i_cmd.emit) begin
            if (r_cnt[emit_idx] != llaa_pkg::COUNT_MAX) begin
                r_cnt[emit_idx] <= r_cnt[emit_idx] + llaa_pkg::CNT_W'(1);
            end
        end else if (i_cmd.release_op) begin
            if ((llaa_pkg::N_W'(rel_idx) < i_num_active) && (r_cnt[rel_idx] != '0)) begin
                r_cnt[rel_idx] <= r_cnt[rel_idx] - llaa_pkg::CNT_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.address_index <= emit_idx;
            r_out.last_of_batch <= o_status.batch_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

### src/least_loaded_address_assigner_core.sv
// an assign item is accepted, ranked by a rank pass over the n addresses in use, ordered by
// a place pass, then gives one result per cycle while the output is not stalled
// a release or an empty assign is handled in its accept cycle; no new item is taken until an
// assign has emitted all its results; the single shared rank comparator row sets the rank
// pass length
// reset: synchronous active low; all use counts zero, addresses_in_use 1, output empty
module least_loaded_address_assigner_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item input
    input  logic                 i_valid,
    output logic                 o_stall,
    input  llaa_pkg::t_in_item   i_data,
    // result output
    output logic                 o_valid,
    input  logic                 i_stall,
    output llaa_pkg::t_out_item  o_data,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [llaa_pkg::N_W-1:0] r_addrs_in_use;
    logic [llaa_pkg::N_W-1:0] num_active;
    llaa_pkg::t_cmd           cmd;
    llaa_pkg::t_status        status;
    llaa_pkg::t_state         state;

    // configuration register
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addrs_in_use <= llaa_pkg::N_W'(1);
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == llaa_pkg::REG_ADDRS_IN_USE)) begin
            r_addrs_in_use <= pwdata[llaa_pkg::N_W-1:0];
        end
    end

    assign prdata = (paddr[2] == llaa_pkg::REG_ADDRS_IN_USE)
                  ? {{(32-llaa_pkg::N_W){1'b0}}, r_addrs_in_use} : '0;

    // clamp to table size
    assign num_active = (r_addrs_in_use > llaa_pkg::N_W'(llaa_pkg::NUM_ADDRS))
                      ? llaa_pkg::N_W'(llaa_pkg::NUM_ADDRS) : r_addrs_in_use;

    llaa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_stall  (o_stall),
        .o_cmd    (cmd),
        .o_state  (state)
    );

    llaa_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_data       (i_data),
        .i_num_active (num_active),
        .i_cmd        (cmd),
        .i_stall      (i_stall),
        .o_status     (status),
        .o_valid      (o_valid),
        .o_data       (o_data)
    );

    // handed-out index always lies inside the active table
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (llaa_pkg::N_W'(o_data.address_index) < num_active))
        else $error("address index outside active table");

    // once the last result of a batch is taken with no new one loaded, the output empties
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_data.last_of_batch && !cmd.emit) |=> !o_valid)
        else $error("result right after end of batch");

    // emitting with a free output slot always fills it
    a_emit_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((state == llaa_pkg::ST_EMIT) && status.out_free) |=> o_valid)
        else $error("emit did not load output register");

    // no item is taken during the rank or place pass
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.rank_step || cmd.place_step) |-> (o_stall && !cmd.start && !cmd.release_op))
        else $error("item accepted during batch");

endmodule
